// ===== design/nps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nps_pkg: shared types and constants of the priority scheduler
// Store depth, derived widths, the process record and the controller states.
// ----------------------------------------------------------------------------
package nps_pkg;

    // Number of process records held per batch
    localparam int MAX_PROCS = 16;

    // Store index and fill count widths
    localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W = $clog2(MAX_PROCS + 1);

    // Result time fields
    localparam int TIME_W = 21;

    // Scheduler clock: latest arrival plus every burst must fit
    localparam int TICK_NAT = $clog2(65536 * (MAX_PROCS + 1));
    localparam int TICK_W   = (TICK_NAT > TIME_W) ? TICK_NAT : TIME_W;

    // One stored process record
    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] arr;
        logic [15:0] burst;
        logic [7:0]  prio;
    } rec_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_EMIT
    } state_t;

endpackage : nps_pkg
`default_nettype wire

// ===== design/nonpreemptive_priority_scheduler_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nonpreemptive_priority_scheduler_top: non-preemptive priority scheduler
// Loads process records into a record memory, then runs them in priority
// order (ties: earlier arrival, then load order) and reports completion,
// turnaround and waiting time per process in execution order.
// ----------------------------------------------------------------------------
// Loading: one record transaction per cycle in the load state, no result
// until the marked one. Scheduling: each result takes one scan of the record
// memory through its single read port, a registered read and a pick/emit
// step that waits for a free output, so a batch takes one scan per record.
// Reset (rst_n low, asynchronous): empty store, clock at zero, load state,
// no result pending. The record memory itself is not cleared.

module nonpreemptive_priority_scheduler_top (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  proc_id,
    input  wire logic [15:0] arrival_time,
    input  wire logic [15:0] burst_time,
    input  wire logic [7:0]  prio_level,
    input  wire logic        last_proc,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_proc_id,
    output logic [20:0]      completion_time,
    output logic [20:0]      turnaround_time,
    output logic [20:0]      waiting_time,
    output logic             last_result
);

    localparam int MAXP  = nps_pkg::MAX_PROCS;
    localparam int IDX_W = nps_pkg::IDX_W;
    localparam int CNT_W = nps_pkg::CNT_W;
    localparam int TW    = nps_pkg::TICK_W;
    localparam int OW    = nps_pkg::TIME_W;

    // Record memory
    nps_pkg::rec_t mem [MAXP];
    nps_pkg::rec_t rd_data_reg;

    // Control state
    nps_pkg::state_t   state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  k_reg;
    logic [CNT_W-1:0]  iss_reg;
    logic [TW-1:0]     tick_reg;
    logic [MAXP-1:0]   fin_reg;
    logic              rd_vld_reg;
    logic [IDX_W-1:0]  rd_idx_reg;

    // Best candidates of the current scan
    logic              have_rdy_reg, have_fut_reg;
    nps_pkg::rec_t     rdy_rec_reg, fut_rec_reg;
    logic [IDX_W-1:0]  rdy_idx_reg, fut_idx_reg;

    // Output register
    logic              out_valid_reg;
    logic [7:0]        out_id_reg;
    logic [OW-1:0]     out_done_reg, out_tat_reg, out_wt_reg;
    logic              out_last_reg;

    // Decoded controls
    logic              load_st, scan_st, emit_st;
    logic              in_acc, out_free, emit_go, issue, store_wr;
    logic              scan_last, batch_last;
    logic [CNT_W-1:0]  cnt_m1;

    // Scan compare
    nps_pkg::rec_t     cur;
    logic              cur_fin, cur_ready, rdy_better, fut_better, upd_rdy, upd_fut;

    // Pick / result arithmetic
    nps_pkg::rec_t     pick;
    logic [IDX_W-1:0]  pick_idx;
    logic [TW-1:0]     base, done, tat, wt;

    // State decode
    always_comb
    begin
        load_st = (state_reg == nps_pkg::ST_LOAD);
        scan_st = (state_reg == nps_pkg::ST_SCAN);
        emit_st = (state_reg == nps_pkg::ST_EMIT);
    end

    // Handshake and sequencing terms
    always_comb
    begin
        in_stall   = !load_st;
        in_acc     = in_valid && load_st;
        store_wr   = in_acc && (cnt_reg < CNT_W'(MAXP));
        out_free   = !out_valid_reg || !out_stall;
        emit_go    = emit_st && out_free;
        issue      = scan_st && (iss_reg < cnt_reg);
        cnt_m1     = cnt_reg - CNT_W'(1);
        scan_last  = rd_vld_reg && (CNT_W'(rd_idx_reg) == cnt_m1);
        batch_last = (k_reg == cnt_m1);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nps_pkg::ST_LOAD:
            begin
                if (in_acc && last_proc)
                begin
                    state_next = nps_pkg::ST_SCAN;
                end
            end
            nps_pkg::ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = nps_pkg::ST_EMIT;
                end
            end
            nps_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = batch_last ? nps_pkg::ST_LOAD : nps_pkg::ST_SCAN;
                end
            end
            default:
            begin
                state_next = nps_pkg::ST_LOAD;
            end
        endcase
    end

    // Record memory: write on load, registered read during scan
    always_ff @(posedge clk)
    begin
        if (store_wr)
        begin
            mem[cnt_reg[IDX_W-1:0]] <= '{id: proc_id, arr: arrival_time,
                                          burst: burst_time, prio: prio_level};
        end
        if (issue)
        begin
            rd_data_reg <= mem[iss_reg[IDX_W-1:0]];
        end
    end

    // Scan compare: best ready process and earliest pending arrival
    always_comb
    begin
        cur        = rd_data_reg;
        cur_fin    = fin_reg[rd_idx_reg];
        cur_ready  = !cur_fin && (TW'(cur.arr) <= tick_reg);
        rdy_better = !have_rdy_reg || (cur.prio < rdy_rec_reg.prio) ||
                     ((cur.prio == rdy_rec_reg.prio) && (cur.arr < rdy_rec_reg.arr));
        fut_better = !have_fut_reg || (cur.arr < fut_rec_reg.arr) ||
                     ((cur.arr == fut_rec_reg.arr) && (cur.prio < fut_rec_reg.prio));
        upd_rdy    = scan_st && rd_vld_reg && cur_ready && rdy_better;
        upd_fut    = scan_st && rd_vld_reg && !cur_fin && fut_better;
    end

    // Pick and time arithmetic; with nothing ready the clock jumps ahead
    always_comb
    begin
        pick     = have_rdy_reg ? rdy_rec_reg : fut_rec_reg;
        pick_idx = have_rdy_reg ? rdy_idx_reg : fut_idx_reg;
        base     = have_rdy_reg ? tick_reg : TW'(fut_rec_reg.arr);
        done     = base + TW'(pick.burst);
        tat      = done - TW'(pick.arr);
        wt       = base - TW'(pick.arr);
    end

    // Candidate payload
    always_ff @(posedge clk)
    begin
        rd_idx_reg <= iss_reg[IDX_W-1:0];
        if (upd_rdy)
        begin
            rdy_rec_reg <= cur;
            rdy_idx_reg <= rd_idx_reg;
        end
        if (upd_fut)
        begin
            fut_rec_reg <= cur;
            fut_idx_reg <= rd_idx_reg;
        end
        if (emit_go)
        begin
            out_id_reg   <= pick.id;
            out_done_reg <= OW'(done);
            out_tat_reg  <= OW'(tat);
            out_wt_reg   <= OW'(wt);
            out_last_reg <= batch_last;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nps_pkg::ST_LOAD;
            cnt_reg       <= '0;
            k_reg         <= '0;
            iss_reg       <= '0;
            tick_reg      <= '0;
            fin_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            have_rdy_reg  <= 1'b0;
            have_fut_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= issue;

            // Load count
            if (store_wr)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end

            // Read address sweep
            if (issue)
            begin
                iss_reg <= iss_reg + CNT_W'(1);
            end

            // Candidate flags
            if (upd_rdy)
            begin
                have_rdy_reg <= 1'b1;
            end
            if (upd_fut)
            begin
                have_fut_reg <= 1'b1;
            end

            // Emit: advance the clock, mark done, restart or end the batch
            if (emit_go)
            begin
                iss_reg      <= '0;
                have_rdy_reg <= 1'b0;
                have_fut_reg <= 1'b0;
                if (batch_last)
                begin
                    cnt_reg  <= '0;
                    k_reg    <= '0;
                    tick_reg <= '0;
                    fin_reg  <= '0;
                end
                else
                begin
                    k_reg             <= k_reg + CNT_W'(1);
                    tick_reg          <= done;
                    fin_reg[pick_idx] <= 1'b1;
                end
            end

            // Output transaction
            if (emit_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Ports
    assign out_valid       = out_valid_reg;
    assign out_proc_id     = out_id_reg;
    assign completion_time = out_done_reg;
    assign turnaround_time = out_tat_reg;
    assign waiting_time    = out_wt_reg;
    assign last_result     = out_last_reg;

    // Assertions
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAXP))
        else $error("load count beyond store depth");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> (CNT_W'(rd_idx_reg) < cnt_reg))
        else $error("scan read beyond loaded records");

    a_emit_candidate: assert property (@(posedge clk) disable iff (!rst_n)
        emit_st |-> (have_rdy_reg || have_fut_reg))
        else $error("emit without an unfinished candidate");

    a_pick_unfinished: assert property (@(posedge clk) disable iff (!rst_n)
        emit_st |-> !fin_reg[pick_idx])
        else $error("picked process already finished");

    a_batch_end: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_go && batch_last) |=> (load_st && (cnt_reg == '0) && (fin_reg == '0)))
        else $error("store not emptied after final result");

endmodule : nonpreemptive_priority_scheduler_top
`default_nettype wire

// ===== bench/tb_nonpreemptive_priority_scheduler_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nonpreemptive_priority_scheduler_top: self-checking bench of the scheduler
// Loads batches of process records, schedules each batch in a local
// predictor and checks every result transaction field by field against it.
// Covers tie breaks, clock jumps over idle time, zero bursts, extreme values,
// store overflow and random batches under random stalls on both sides.
// ----------------------------------------------------------------------------

module tb_nonpreemptive_priority_scheduler_top;

    // One expected result transaction
    typedef struct {
        logic [7:0]                  id;
        logic [nps_pkg::TIME_W-1:0]  completion;
        logic [nps_pkg::TIME_W-1:0]  turnaround;
        logic [nps_pkg::TIME_W-1:0]  waiting;
        logic                        last;
    } sched_result_t;

    // Shapes of random batches
    typedef enum int {
        PROF_DENSE,
        PROF_WIDE,
        PROF_SPARSE
    } batch_profile_t;

    localparam int MAX_REPORTS = 10;

    logic        clk             = 1'b0;
    logic        rst_n           = 1'b0;
    logic        in_valid        = 1'b0;
    logic        in_stall;
    logic [7:0]  proc_id         = '0;
    logic [15:0] arrival_time    = '0;
    logic [15:0] burst_time      = '0;
    logic [7:0]  prio_level      = '0;
    logic        last_proc       = 1'b0;
    logic        out_valid;
    logic        out_stall       = 1'b0;
    logic [7:0]  out_proc_id;
    logic [20:0] completion_time;
    logic [20:0] turnaround_time;
    logic [20:0] waiting_time;
    logic        last_result;

    // Predictor state: records of the batch being loaded, results still owed
    nps_pkg::rec_t held_records[$];
    sched_result_t expected_schedule[$];

    bit idling_on     = 1'b1;
    int fail_count    = 0;
    int records_sent  = 0;
    int batches_sent  = 0;
    int results_seen  = 0;

    always #2 clk = ~clk;

    nonpreemptive_priority_scheduler_top i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .proc_id         (proc_id),
        .arrival_time    (arrival_time),
        .burst_time      (burst_time),
        .prio_level      (prio_level),
        .last_proc       (last_proc),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_proc_id     (out_proc_id),
        .completion_time (completion_time),
        .turnaround_time (turnaround_time),
        .waiting_time    (waiting_time),
        .last_result     (last_result)
    );

    // Non-preemptive priority pass over the held batch; queues one result
    // per process in execution order and empties the batch
    task automatic run_priority_schedule();
        bit             finished[nps_pkg::MAX_PROCS];
        logic [63:0]    tick;
        logic [63:0]    next_arr;
        logic [63:0]    tat;
        bit             any_ready;
        bit             have;
        int             pick;
        int             n;
        nps_pkg::rec_t  p;
        nps_pkg::rec_t  c;
        sched_result_t  res;
        n    = held_records.size();
        tick = '0;
        foreach (finished[i]) finished[i] = 1'b0;
        for (int k = 0; k < n; k++)
        begin
            // jump the clock when nothing unfinished has arrived yet
            any_ready = 1'b0;
            next_arr  = '1;
            for (int i = 0; i < n; i++)
            begin
                if (finished[i])
                    continue;
                if (64'(held_records[i].arr) <= tick)
                    any_ready = 1'b1;
                if (64'(held_records[i].arr) < next_arr)
                    next_arr = 64'(held_records[i].arr);
            end
            if (!any_ready)
                tick = next_arr;

            // lowest priority number, then earliest arrival, then load order
            have = 1'b0;
            pick = 0;
            for (int i = 0; i < n; i++)
            begin
                c = held_records[i];
                p = held_records[pick];
                if (finished[i] || 64'(c.arr) > tick)
                    continue;
                if (!have || c.prio < p.prio || (c.prio == p.prio && c.arr < p.arr))
                begin
                    pick = i;
                    have = 1'b1;
                end
            end

            p              = held_records[pick];
            tick           = tick + 64'(p.burst);
            finished[pick] = 1'b1;
            tat            = tick - 64'(p.arr);
            res.id         = p.id;
            res.completion = tick[nps_pkg::TIME_W-1:0];
            res.turnaround = tat[nps_pkg::TIME_W-1:0];
            res.waiting    = tat[nps_pkg::TIME_W-1:0] - nps_pkg::TIME_W'(p.burst);
            res.last       = (k == n - 1);
            expected_schedule.push_back(res);
        end
        held_records.delete();
        batches_sent++;
    endtask

    // Drive one record transaction, wait for acceptance, update the predictor
    task automatic send_record(input logic [7:0] id, input logic [15:0] arr,
                               input logic [15:0] burst, input logic [7:0] prio,
                               input logic last);
        nps_pkg::rec_t rec;
        rec = '{id: id, arr: arr, burst: burst, prio: prio};
        if (idling_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        proc_id      <= id;
        arrival_time <= arr;
        burst_time   <= burst;
        prio_level   <= prio;
        last_proc    <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        records_sent++;
        // a full store drops the record, but the mark still starts the pass
        if (held_records.size() < nps_pkg::MAX_PROCS)
            held_records.push_back(rec);
        if (last)
            run_priority_schedule();
    endtask

    // Single record with every field at its maximum
    task automatic test_single_extremes();
        send_record(8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
    endtask

    // Idle start, clock jumps, zero burst, ties on priority and arrival
    task automatic test_ties_and_gaps();
        send_record(8'h00, 16'd5,  16'd0, 8'd3, 1'b0);
        send_record(8'h11, 16'd5,  16'd2, 8'd3, 1'b0);
        send_record(8'h22, 16'd2,  16'd5, 8'd3, 1'b0);
        send_record(8'h33, 16'd40, 16'd6, 8'd0, 1'b0);
        send_record(8'h66, 16'd4,  16'd3, 8'd3, 1'b1);
    endtask

    // Full store of maximum times, then two dropped records, the last marked
    task automatic test_store_overflow();
        for (int i = 0; i < nps_pkg::MAX_PROCS; i++)
            send_record(8'(i), 16'hFFFF, 16'hFFFF, 8'($urandom_range(0, 255)), 1'b0);
        send_record(8'hA0, 16'h0000, 16'h0001, 8'h00, 1'b0);
        send_record(8'hA1, 16'h0000, 16'h0001, 8'h00, 1'b1);
    endtask

    // Random batches of mixed shape; idling stops for the last part
    task automatic test_random_batches();
        int             sent;
        int             n;
        batch_profile_t prof;
        logic [15:0]    arr;
        logic [15:0]    burst;
        logic [7:0]     prio;
        sent = 0;
        while (sent < 75)
        begin
            if (sent >= 55)
                idling_on = 1'b0;
            n    = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 20)
                                               : $urandom_range(1, 16);
            prof = batch_profile_t'($urandom_range(0, 2));
            for (int j = 0; j < n; j++)
            begin
                case (prof)
                    PROF_DENSE:
                    begin
                        arr   = 16'($urandom_range(0, 40));
                        burst = 16'($urandom_range(0, 12));
                        prio  = 8'($urandom_range(0, 3));
                    end
                    PROF_WIDE:
                    begin
                        arr   = 16'($urandom);
                        burst = 16'($urandom);
                        prio  = 8'($urandom);
                    end
                    default:
                    begin
                        arr   = 16'($urandom);
                        burst = 16'($urandom_range(0, 255));
                        prio  = 8'($urandom_range(0, 7));
                    end
                endcase
                send_record(8'($urandom), arr, burst, prio, j == n - 1);
            end
            sent += n;
        end
    endtask

    // Result stall: random bursts, quiet stretches, none at the end
    always
    begin
        @(posedge clk);
        if (idling_on && $urandom_range(0, 5) == 0)
        begin
            out_stall <= 1'b1;
            repeat ($urandom_range(1, 15)) @(posedge clk);
            out_stall <= 1'b0;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(20, 60)) @(posedge clk);
        end
    end

    // Compare each accepted result transaction with the oldest expectation
    always @(posedge clk)
    begin
        sched_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_schedule.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("[%0t] unexpected result: id=%0d done=%0d tat=%0d wait=%0d last=%0b",
                             $realtime, out_proc_id, completion_time, turnaround_time,
                             waiting_time, last_result);
            end
            else
            begin
                want = expected_schedule.pop_front();
                if (out_proc_id !== want.id || completion_time !== want.completion ||
                    turnaround_time !== want.turnaround || waiting_time !== want.waiting ||
                    last_result !== want.last)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                    begin
                        $display("[%0t] mismatch exp: id=%0d done=%0d tat=%0d wait=%0d last=%0b",
                                 $realtime, want.id, want.completion, want.turnaround,
                                 want.waiting, want.last);
                        $display("[%0t]          got: id=%0d done=%0d tat=%0d wait=%0d last=%0b",
                                 $realtime, out_proc_id, completion_time, turnaround_time,
                                 waiting_time, last_result);
                    end
                end
            end
        end
    end

    // Test sequence
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_single_extremes();
        test_ties_and_gaps();
        test_store_overflow();
        test_random_batches();
        in_valid <= 1'b0;

        // drain, then allow time for any stray result
        while (expected_schedule.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Sent %0d records in %0d batches; checked %0d scheduled results.",
                 records_sent, batches_sent, results_seen);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog against a hung handshake
    initial
    begin
        #2_000_000;
        $display("Timeout with %0d results outstanding", expected_schedule.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
